@@ sv/ffha_pkg.sv @@
// ============================================================================
// ffha_pkg - shared types and constants of the first-fit heap allocator
// Holds table geometry, status codes and the command codes.
// ============================================================================
`default_nettype none

package ffha_pkg;

   localparam int SegCount  = 64;
   localparam int SegBits   = $clog2(SegCount);
   localparam int AddrBits  = 20;
   localparam int SizeBits  = AddrBits + 1;
   localparam int MarginBits = 8;

   typedef logic [AddrBits-1:0] offs_type;
   typedef logic [SizeBits-1:0] size_type;
   typedef logic [SegBits-1:0]  idx_type;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_NOFIT    = 2'd1,
      ST_NOTFOUND = 2'd2
   } status_type;

   localparam logic CMD_ALLOC = 1'b0;
   localparam logic CMD_FREE  = 1'b1;

   localparam logic CSR_HEAP_SIZE    = 1'b0;
   localparam logic CSR_SPLIT_MARGIN = 1'b1;

   localparam size_type HeapLimit = size_type'(1) << AddrBits;

   // One table entry as it sits in the segment memory.
   typedef struct packed {
      offs_type start;
      size_type length;
      logic     is_free;
      logic     has_next;
      idx_type  link;
   } seg_type;

endpackage

`default_nettype wire

@@ sv/first_fit_heap_allocator_core.sv @@
// ============================================================================
// first_fit_heap_allocator_core - first-fit heap segment allocator
// Walks an address-ordered linked segment table held in one synchronous
// memory, serving allocate and free requests one at a time.
// ============================================================================
//
//  Channel | Dir | Handshake            | Payload
//  req     | in  | req_tvalid/tready    | tdata: cmd, alloc_size, block_offset
//  rsp     | out | rsp_tvalid/tready    | tdata: status, result_offset
//  csr     | in  | csr_we               | csr_index, csr_wdata
//
// A request walks the table from the head, each entry through a memory read
// (S_READ) and then a decision (S_EVAL), as the segment memory has a single
// read port; the next request is taken only once the result word has moved to
// the output register. Finding a spare entry for a split is a combinational
// search over a 64-bit valid vector held in flip-flops. After reset, or after a
// write of heap_size, state S_INIT makes the table one free segment: the valid
// vector is set to entry zero alone and entry zero is rewritten.
// A result word waits in the output register while the next request may already
// be taken; the walk stalls only when a new result is ready and the old one is
// still held.
`default_nettype none

module first_fit_heap_allocator_core (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          req_tvalid,
   output logic                               req_tready,
   // tdata: [0] cmd, [21:1] alloc_size, [41:22] block_offset, [47:42] zero
   input  wire logic [47:0]                   req_tdata,
   output logic                               rsp_tvalid,
   input  wire logic                          rsp_tready,
   // tdata: [1:0] status, [21:2] result_offset, [23:22] zero
   output logic [23:0]                        rsp_tdata,
   input  wire logic                          csr_we,
   input  wire logic                          csr_index,
   input  wire logic [ffha_pkg::SizeBits-1:0] csr_wdata
);
   import ffha_pkg::*;

   typedef enum logic [2:0] {
      S_INIT, S_IDLE, S_READ, S_EVAL, S_NEXT, S_MERGE, S_DONE
   } state_type;

   // The segment table; one write and one read port, read data registered.
   seg_type mem [SegCount];
   seg_type rd_ff;
   idx_type rd_addr;
   logic    wr_en;
   idx_type wr_addr;
   seg_type wr_data;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_ff <= mem[rd_addr];
   end

   state_type  state_ff, state_in;
   logic [SegCount-1:0] valid_ff, valid_in;
   size_type   heap_ff, heap_in;
   logic [MarginBits-1:0] margin_ff, margin_in;
   logic       cmd_ff, cmd_in;
   size_type   size_ff, size_in;
   offs_type   offs_ff, offs_in;
   idx_type    cur_ff, cur_in;
   seg_type    cur_seg_ff, cur_seg_in;
   logic [SegBits:0] steps_ff, steps_in;
   status_type res_st_ff, res_st_in;
   offs_type   res_off_ff, res_off_in;
   logic       out_v_ff, out_v_in;
   status_type out_st_ff, out_st_in;
   offs_type   out_off_ff, out_off_in;

   // Lowest invalid entry, a priority search over the valid vector.
   logic    spare_ok;
   idx_type spare;
   always_comb begin
      spare_ok = 1'b0;
      spare    = '0;
      for (int i = SegCount - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            spare_ok = 1'b1;
            spare    = idx_type'(i);
         end
      end
   end

   logic [SizeBits:0] need;
   size_type          csr_size;
   logic              out_free;
   assign need     = {1'b0, size_ff} + (SizeBits+1)'(margin_ff);
   assign csr_size = (csr_wdata > HeapLimit) ? HeapLimit : csr_wdata;
   assign out_free = !out_v_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE) && !csr_we;

   always_comb begin
      state_in   = state_ff;
      valid_in   = valid_ff;
      heap_in    = heap_ff;
      margin_in  = margin_ff;
      cmd_in     = cmd_ff;
      size_in    = size_ff;
      offs_in    = offs_ff;
      cur_in     = cur_ff;
      cur_seg_in = cur_seg_ff;
      steps_in   = steps_ff;
      res_st_in  = res_st_ff;
      res_off_in = res_off_ff;
      out_v_in   = out_v_ff && !rsp_tready;
      out_st_in  = out_st_ff;
      out_off_in = out_off_ff;
      rd_addr    = cur_ff;
      wr_en      = 1'b0;
      wr_addr    = cur_ff;
      wr_data    = cur_seg_ff;

      unique case (state_ff)
         S_INIT: begin
            wr_en    = 1'b1;
            wr_addr  = '0;
            wr_data  = '{start: '0, length: heap_ff, is_free: 1'b1,
                         has_next: 1'b0, link: '0};
            valid_in = SegCount'(1);
            state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd_in   = req_tdata[0];
               size_in  = req_tdata[21:1];
               offs_in  = req_tdata[41:22];
               cur_in   = '0;
               steps_in = '0;
               res_off_in = '0;
               res_st_in  = (req_tdata[0] == CMD_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_EVAL;
         end
         S_EVAL: begin
            cur_seg_in = rd_ff;
            state_in   = S_NEXT;
            if (cmd_ff == CMD_ALLOC) begin
               if (rd_ff.is_free && rd_ff.length >= size_ff) begin
                  res_st_in  = ST_OK;
                  res_off_in = rd_ff.start;
                  wr_en      = 1'b1;
                  wr_data    = rd_ff;
                  wr_data.is_free = 1'b0;
                  if ({1'b0, rd_ff.length} > need && spare_ok) begin
                     wr_data.has_next = 1'b1;
                     wr_data.link     = spare;
                     wr_data.length   = size_ff;
                     // Remainder written in the next cycle.
                     cur_seg_in.start  = rd_ff.start + offs_type'(size_ff);
                     cur_seg_in.length = rd_ff.length - size_ff;
                     cur_seg_in.is_free = 1'b1;
                     cur_in   = spare;
                     valid_in[spare] = 1'b1;
                     state_in = S_MERGE;
                  end else begin
                     state_in = S_DONE;
                  end
               end
            end else if (rd_ff.start == offs_ff) begin
               res_st_in = ST_OK;
               wr_en     = 1'b1;
               wr_data   = rd_ff;
               wr_data.is_free = 1'b1;
               if (rd_ff.has_next) begin
                  cur_seg_in.is_free = 1'b1;
                  rd_addr  = rd_ff.link;
                  state_in = S_MERGE;
               end else begin
                  state_in = S_DONE;
               end
            end
            if (state_in == S_NEXT) begin
               if (!rd_ff.has_next || steps_ff == (SegBits+1)'(SegCount - 1)) begin
                  state_in = S_DONE;
               end else begin
                  cur_in   = rd_ff.link;
                  steps_in = steps_ff + 1'b1;
                  state_in = S_READ;
               end
               rd_addr = rd_ff.link;
            end
         end
         S_MERGE: begin
            if (cmd_ff == CMD_ALLOC) begin
               // Write the split remainder into the spare entry.
               wr_en = 1'b1;
               state_in = S_DONE;
            end else begin
               // rd_ff holds the successor of the freed entry.
               if (rd_ff.is_free) begin
                  wr_en   = 1'b1;
                  wr_data = cur_seg_ff;
                  wr_data.length   = cur_seg_ff.length + rd_ff.length;
                  wr_data.has_next = rd_ff.has_next;
                  wr_data.link     = rd_ff.link;
                  valid_in[cur_seg_ff.link] = 1'b0;
               end
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               out_v_in   = 1'b1;
               out_st_in  = res_st_ff;
               out_off_in = res_off_ff;
               state_in   = S_IDLE;
            end
         end
         S_NEXT: begin
            state_in = S_DONE;
         end
         default: state_in = S_IDLE;
      endcase

      if (csr_we) begin
         if (csr_index == CSR_HEAP_SIZE) begin
            heap_in  = csr_size;
            state_in = S_INIT;
         end else begin
            margin_in = csr_wdata[MarginBits-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_INIT;
         valid_ff  <= '0;
         heap_ff   <= HeapLimit;
         margin_ff <= MarginBits'(32);
         out_v_ff  <= 1'b0;
      end else begin
         state_ff  <= state_in;
         valid_ff  <= valid_in;
         heap_ff   <= heap_in;
         margin_ff <= margin_in;
         out_v_ff  <= out_v_in;
      end
      cmd_ff     <= cmd_in;
      size_ff    <= size_in;
      offs_ff    <= offs_in;
      cur_ff     <= cur_in;
      cur_seg_ff <= cur_seg_in;
      steps_ff   <= steps_in;
      res_st_ff  <= res_st_in;
      res_off_ff <= res_off_in;
      out_st_ff  <= out_st_in;
      out_off_ff <= out_off_in;
   end

   assign rsp_tvalid = out_v_ff;
   assign rsp_tdata  = {2'b00, out_off_ff, out_st_ff};

`ifndef SYNTHESIS
   // The head entry is always part of the table once initialised.
   a_head_valid: assert property (@(posedge clock) disable iff (reset)
      (state_ff != S_INIT) |-> valid_ff[0])
      else $error("head entry lost its valid bit");

   // A taken request always moves the block out of idle.
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> (state_ff != S_IDLE))
      else $error("request accepted without leaving idle");

   // A held result word keeps its status while stalled.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(out_st_ff))
      else $error("result word changed while stalled");
`endif

endmodule

`default_nettype wire

@@ bench/first_fit_heap_allocator_core_tb.sv @@
// ============================================================================
// first_fit_heap_allocator_core_tb - self-checking bench of the heap allocator
// Drives allocate and free requests under random stalls, keeps its own copy of
// the segment table, predicts every response word and checks it in order.
// ============================================================================
`default_nettype none

module first_fit_heap_allocator_core_tb;
   import ffha_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int WatchdogLimit = 20000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   // tdata: [0] cmd, [21:1] alloc_size, [41:22] block_offset, [47:42] zero
   logic [47:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   // tdata: [1:0] status, [21:2] result_offset, [23:22] zero
   logic [23:0] rsp_tdata;
   logic        csr_we = 1'b0;
   logic        csr_index = 1'b0;
   logic [SizeBits-1:0] csr_wdata = '0;

   // The predicted response of one request.
   typedef struct packed {
      status_type status;
      offs_type   offset;
   } answer_type;

   // Our own copy of the allocator state.
   size_type heap_bytes;
   logic [7:0] margin;
   offs_type seg_base [SegCount];
   size_type seg_len  [SegCount];
   logic     seg_free [SegCount];
   idx_type  seg_next [SegCount];
   logic     seg_used [SegCount];
   logic     seg_more [SegCount];

   answer_type pending_answers[$];
   offs_type   live_offsets[$];     // offsets currently handed out
   int  error_count = 0;
   int  idle_cycles = 0;
   int  stall_left = 0;
   bit  stall_hold = 0;

   first_fit_heap_allocator_core dut (.*);

   always #6 clock = ~clock;

   // Every watched cycle without any accepted word counts towards the limit.
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || csr_we)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   function automatic int gap_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 40) return 0;
      if (pick < 90) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   // The receiver stalls in runs of random length, mostly short and now and
   // then long; the stall_hold switch of the directed test keeps it ready.
   always @(posedge clock) begin
      if (reset || stall_hold) begin
         rsp_tready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left > 0) begin
         rsp_tready <= 1'b0;
         stall_left <= stall_left - 1;
      end else if ($urandom_range(0, 99) < 30) begin
         rsp_tready <= 1'b0;
         stall_left <= gap_length();
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Checks each response word against the oldest prediction.
   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_answers.size() == 0) begin
            $display("%0t: unexpected response status=%0d offset=%0h", $time,
                     rsp_tdata[1:0], rsp_tdata[21:2]);
            error_count++;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_tdata[1:0] !== want.status) begin
               $display("%0t: status expected %0d actual %0d", $time,
                        want.status, rsp_tdata[1:0]);
               error_count++;
            end
            if (rsp_tdata[21:2] !== want.offset) begin
               $display("%0t: offset expected %0h actual %0h", $time,
                        want.offset, rsp_tdata[21:2]);
               error_count++;
            end
         end
      end
   end

   function automatic void rebuild_table();
      for (int i = 0; i < SegCount; i++) begin
         seg_base[i] = '0; seg_len[i] = '0; seg_free[i] = 1'b0;
         seg_next[i] = '0; seg_used[i] = 1'b0; seg_more[i] = 1'b0;
      end
      seg_len[0]  = heap_bytes;
      seg_free[0] = 1'b1;
      seg_used[0] = 1'b1;
      live_offsets.delete();
   endfunction

   // Walks the table the way the allocator does and updates our copy.
   function automatic answer_type serve_request(logic cmd, size_type want_size,
                                                offs_type where);
      answer_type ans;
      idx_type cur;
      idx_type spare;
      idx_type nxt;
      bit found_spare;
      cur = '0;
      ans.status = (cmd == CMD_ALLOC) ? ST_NOFIT : ST_NOTFOUND;
      ans.offset = '0;
      for (int step = 0; step < SegCount; step++) begin
         if (cmd == CMD_ALLOC) begin
            if (seg_free[cur] && seg_len[cur] >= want_size) begin
               found_spare = 0;
               for (int i = 0; i < SegCount; i++)
                  if (!found_spare && !seg_used[i]) begin
                     spare = idx_type'(i);
                     found_spare = 1;
                  end
               if ({1'b0, seg_len[cur]} > {1'b0, want_size} + margin && found_spare) begin
                  seg_base[spare] = seg_base[cur] + offs_type'(want_size);
                  seg_len[spare]  = seg_len[cur] - want_size;
                  seg_free[spare] = 1'b1;
                  seg_used[spare] = 1'b1;
                  seg_more[spare] = seg_more[cur];
                  seg_next[spare] = seg_next[cur];
                  seg_more[cur] = 1'b1;
                  seg_next[cur] = spare;
                  seg_len[cur]  = want_size;
               end
               seg_free[cur] = 1'b0;
               ans.status = ST_OK;
               ans.offset = seg_base[cur];
               return ans;
            end
         end else if (seg_base[cur] == where) begin
            seg_free[cur] = 1'b1;
            if (seg_more[cur] && seg_free[seg_next[cur]]) begin
               nxt = seg_next[cur];
               seg_len[cur]  = seg_len[cur] + seg_len[nxt];
               seg_more[cur] = seg_more[nxt];
               seg_next[cur] = seg_next[nxt];
               seg_used[nxt] = 1'b0; seg_more[nxt] = 1'b0; seg_next[nxt] = '0;
               seg_base[nxt] = '0;   seg_len[nxt]  = '0;   seg_free[nxt] = 1'b0;
            end
            ans.status = ST_OK;
            return ans;
         end
         if (!seg_more[cur]) break;
         cur = seg_next[cur];
      end
      return ans;
   endfunction

   // Sends one request word, after a random gap unless no_gap is set, and records its prediction.
   task automatic send_request(logic cmd, size_type want_size, offs_type where,
                               bit no_gap = 0);
      answer_type ans;
      int gap;
      gap = no_gap ? 0 : gap_length();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {6'b0, where, want_size, cmd};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      ans = serve_request(cmd, want_size, where);
      pending_answers.push_back(ans);
      if (cmd == CMD_ALLOC && ans.status == ST_OK) live_offsets.push_back(ans.offset);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_answers.size() != 0) @(posedge clock);
      // Waits on past the last word, though each walk ends before its word is sent.
      repeat (2 * SegCount + 8) @(posedge clock);
   endtask

   // Register writes only while the block has nothing in hand.
   task automatic write_register(logic index, size_type value);
      drain();
      csr_we <= 1'b1;
      csr_index <= index;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (index == CSR_HEAP_SIZE) begin
         heap_bytes = (value > HeapLimit) ? HeapLimit : value;
         rebuild_table();
      end else begin
         margin = value[7:0];
      end
      @(posedge clock);
   endtask

   // Extremes of the fields, over-size requests, freeing twice, freeing an offset
   // that is not a segment start, and heap-size writes that saturate or are zero.
   task automatic test_directed();
      stall_hold = 1;
      send_request(CMD_ALLOC, size_type'(1 << 20) + 21'd1, '0, 1);
      send_request(CMD_ALLOC, 21'h1FFFFF, '0, 1);
      send_request(CMD_ALLOC, 21'd0, '0, 1);
      send_request(CMD_ALLOC, 21'd100, '0);
      send_request(CMD_ALLOC, 21'd4096, '0);
      send_request(CMD_FREE, '0, 20'hFFFFF);
      send_request(CMD_FREE, '0, 20'd0);
      send_request(CMD_FREE, '0, 20'd0);
      send_request(CMD_FREE, '0, 20'd100);
      send_request(CMD_FREE, '0, 20'd7);
      send_request(CMD_ALLOC, size_type'(1 << 20), '0);
      send_request(CMD_FREE, 21'h1FFFFF, 20'd0);
      stall_hold = 0;
      write_register(CSR_SPLIT_MARGIN, 21'd0);
      write_register(CSR_HEAP_SIZE, 21'h1FFFFF);   // saturates to the limit
      send_request(CMD_ALLOC, size_type'(1 << 20), '0);
      write_register(CSR_HEAP_SIZE, 21'd0);
      send_request(CMD_ALLOC, 21'd0, '0);
      send_request(CMD_ALLOC, 21'd1, '0);
      send_request(CMD_FREE, '0, 20'd0);
   endtask

   // Many small allocations until the table has no spare entry left, so the last free
   // segment is served whole and later ones find no fit, then everything is handed back.
   task automatic test_table_full();
      write_register(CSR_HEAP_SIZE, 21'd8000);
      write_register(CSR_SPLIT_MARGIN, 21'd0);
      for (int i = 0; i < 70; i++)
         send_request(CMD_ALLOC, size_type'($urandom_range(0, 40)), '0, i % 3 == 0);
      while (live_offsets.size() != 0)
         send_request(CMD_FREE, '0, live_offsets.pop_back());
   endtask

   // Mostly well-formed traffic: allocations and frees of live offsets, with
   // some bad frees and over-sized requests as noise.
   task automatic test_random(int count, size_type heap, logic [7:0] slack,
                              int size_cap);
      int pick;
      int idx;
      write_register(CSR_HEAP_SIZE, heap);
      write_register(CSR_SPLIT_MARGIN, size_type'(slack));
      for (int i = 0; i < count; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 50)
            send_request(CMD_ALLOC, size_type'($urandom_range(0, size_cap)),
                         offs_type'($urandom));
         else if (pick < 90 && live_offsets.size() != 0) begin
            idx = $urandom_range(0, live_offsets.size() - 1);
            send_request(CMD_FREE, size_type'($urandom), live_offsets[idx]);
            live_offsets.delete(idx);
         end else if (pick < 95)
            send_request(CMD_FREE, size_type'($urandom), offs_type'($urandom));
         else
            send_request(CMD_ALLOC, size_type'($urandom), offs_type'($urandom));
      end
   endtask

   initial begin
      heap_bytes = HeapLimit;
      margin = 8'd32;
      rebuild_table();
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_table_full();
      test_random(375, HeapLimit, 8'd32, 60000);
      test_random(375, 21'd4096, 8'd0, 300);
      test_random(275, 21'd1, 8'd255, 2);
      test_random(275, 21'd700000, 8'd17, 1 << 20);
      drain();
      if (error_count == 0 && pending_answers.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule

`default_nettype wire
